// File: design/sha_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Shared payload types, command codes, round constants, initial hash values and a rotate function.
// ---------------------------------------------------------------------------
package sha_pkg;

    typedef enum logic [1:0] {
        CMD_ABSORB        = 2'd0,
        CMD_ABSORB_FINISH = 2'd1,
        CMD_FINISH        = 2'd2,
        CMD_NONE          = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    // Datapath commands issued by the controller.
    typedef enum logic [2:0] {
        OP_IDLE     = 3'd0,
        OP_ABSORB   = 3'd1,
        OP_PAD      = 3'd2,
        OP_ZERO     = 3'd3,
        OP_LEN      = 3'd4,
        OP_COMP_LD  = 3'd5,
        OP_ROUND    = 3'd6,
        OP_COMP_ADD = 3'd7
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic [5:0] round;
        logic       clear;
    } t_dp_cmd;

    typedef struct packed {
        logic [5:0] fill_count;
    } t_dp_status;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

`default_nettype wire

// File: design/sha_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 datapath
// Message block window, byte counter, working variables and hash state, all
// driven by commands from the controller. The window takes the block bytes
// and then serves as the message schedule during the rounds.
// ---------------------------------------------------------------------------
module sha_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sha_pkg::t_dp_cmd    i_cmd,
    output sha_pkg::t_dp_status      o_status,
    output logic [31:0]              o_hash [8]
);

    logic [5:0]  r_fill;
    logic [60:0] r_bytes;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];

    logic [31:0] s0, s1, w_new, w_cur, big0, big1, ch, maj, t1, t2;
    logic [63:0] bits;
    logic [3:0]  wr_word;
    logic [4:0]  wr_lane;
    logic [5:0]  len_lane;

    assign bits     = {r_bytes, 3'b000};
    assign wr_word  = r_fill[5:2];
    assign wr_lane  = {~r_fill[1:0], 3'b000};
    assign len_lane = {~r_fill[2:0], 3'b000};
    assign s0    = sha_pkg::ror32(r_w[1], 7) ^ sha_pkg::ror32(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1    = sha_pkg::ror32(r_w[14], 17) ^ sha_pkg::ror32(r_w[14], 19)
                   ^ (r_w[14] >> 10);
    assign w_new = r_w[0] + s0 + r_w[9] + s1;
    assign w_cur = r_w[0];
    assign big1  = sha_pkg::ror32(r_v[4], 6) ^ sha_pkg::ror32(r_v[4], 11)
                   ^ sha_pkg::ror32(r_v[4], 25);
    assign ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1    = r_v[7] + big1 + ch + sha_pkg::ROUND_K[i_cmd.round] + w_cur;
    assign big0  = sha_pkg::ror32(r_v[0], 2) ^ sha_pkg::ror32(r_v[0], 13)
                   ^ sha_pkg::ror32(r_v[0], 22);
    assign maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2    = big0 + maj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_bytes <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::INIT_H[i];
        end else if (i_cmd.clear) begin
            r_fill  <= '0;
            r_bytes <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::INIT_H[i];
        end else begin
            case (i_cmd.op)
                sha_pkg::OP_ABSORB: begin
                    r_w[wr_word][wr_lane +: 8] <= i_cmd.data_byte;
                    r_fill  <= r_fill + 6'd1;
                    r_bytes <= r_bytes + 61'd1;
                end
                sha_pkg::OP_PAD: begin
                    r_w[wr_word][wr_lane +: 8] <= sha_pkg::PAD_BYTE;
                    r_fill <= r_fill + 6'd1;
                end
                sha_pkg::OP_ZERO: begin
                    r_w[wr_word][wr_lane +: 8] <= 8'h00;
                    r_fill <= r_fill + 6'd1;
                end
                sha_pkg::OP_LEN: begin
                    r_w[wr_word][wr_lane +: 8] <= bits[len_lane +: 8];
                    r_fill <= r_fill + 6'd1;
                end
                sha_pkg::OP_COMP_LD: begin
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                end
                sha_pkg::OP_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                end
                sha_pkg::OP_COMP_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_status.fill_count = r_fill;
    assign o_hash = r_h;

endmodule

`default_nettype wire

// File: design/sha_controller.sv
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 controller
// Sequences absorption, padding, the compression rounds and digest output.
// ---------------------------------------------------------------------------
module sha_controller (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire sha_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output sha_pkg::t_out_item       o_out_data,
    output sha_pkg::t_dp_cmd         o_dp_cmd,
    input  wire sha_pkg::t_dp_status i_dp_status,
    input  wire logic [31:0]         i_hash [8]
);

    typedef enum logic [3:0] {
        S_IDLE, S_PAD, S_FILL, S_LOAD, S_ROUND, S_ADD, S_OUT
    } t_state;

    t_state      r_state, n_state;
    logic [5:0]  r_round, n_round;
    logic        r_final, n_final;
    logic        r_finish, n_finish;
    logic        r_padded, n_padded;
    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_word, n_word;
    logic        r_ovalid, n_ovalid;
    sha_pkg::t_dp_cmd cmd;
    logic        accept;
    logic [5:0]  fill;

    assign fill   = i_dp_status.fill_count;
    assign accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_round  = r_round;
        n_final  = r_final;
        n_finish = r_finish;
        n_padded = r_padded;
        n_idx    = r_idx;
        n_word   = r_word;
        n_ovalid = r_ovalid;
        cmd      = '{op: sha_pkg::OP_IDLE, data_byte: i_in_data.data_byte,
                     round: r_round, clear: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.cmd)
                        sha_pkg::CMD_ABSORB, sha_pkg::CMD_ABSORB_FINISH: begin
                            cmd.op   = sha_pkg::OP_ABSORB;
                            n_finish = (i_in_data.cmd == sha_pkg::CMD_ABSORB_FINISH);
                            n_final  = 1'b0;
                            n_padded = 1'b0;
                            if (fill == 6'd63) begin
                                n_state = S_LOAD;
                            end else if (n_finish) begin
                                n_state = S_PAD;
                            end
                        end
                        sha_pkg::CMD_FINISH: begin
                            n_finish = 1'b1;
                            n_final  = 1'b0;
                            n_padded = 1'b0;
                            n_state  = S_PAD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PAD: begin
                cmd.op   = sha_pkg::OP_PAD;
                n_padded = 1'b1;
                n_final  = (fill < sha_pkg::LEN_OFFSET);
                n_state  = S_FILL;
                if (fill == 6'd63) n_state = S_LOAD;
            end
            S_FILL: begin
                if (r_final || fill < sha_pkg::LEN_OFFSET) begin
                    cmd.op = (fill >= sha_pkg::LEN_OFFSET) ? sha_pkg::OP_LEN
                                                           : sha_pkg::OP_ZERO;
                end else begin
                    cmd.op = sha_pkg::OP_ZERO;
                end
                if (fill == 6'd63) n_state = S_LOAD;
            end
            S_LOAD: begin
                cmd.op  = sha_pkg::OP_COMP_LD;
                n_round = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                cmd.op  = sha_pkg::OP_ROUND;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) n_state = S_ADD;
            end
            S_ADD: begin
                cmd.op = sha_pkg::OP_COMP_ADD;
                if (!r_finish) begin
                    n_state = S_IDLE;
                end else if (r_final) begin
                    n_state = S_OUT;
                    n_idx   = '0;
                end else if (r_padded) begin
                    n_state = S_FILL;
                    n_final = 1'b1;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    if (r_ovalid && r_idx == 3'd7) begin
                        n_ovalid  = 1'b0;
                        n_state   = S_IDLE;
                        n_finish  = 1'b0;
                        cmd.clear = 1'b1;
                    end else begin
                        n_ovalid = 1'b1;
                        n_idx    = r_ovalid ? r_idx + 3'd1 : 3'd0;
                        n_word   = i_hash[r_ovalid ? r_idx + 3'd1 : 3'd0];
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The flag r_final marks that the block now being filled holds the length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_round  <= '0;
            r_final  <= 1'b0;
            r_finish <= 1'b0;
            r_padded <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
            r_word   <= '0;
        end else begin
            r_state  <= n_state;
            r_round  <= n_round;
            r_final  <= n_final;
            r_finish <= n_finish;
            r_padded <= n_padded;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
            r_word   <= n_word;
        end
    end

    assign o_dp_cmd    = cmd;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = '{digest_word: r_word, word_index: r_idx,
                           last_word: (r_idx == 3'd7)};

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid) else $error("ready while output pending");
    a_out_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state == S_OUT) else $error("output outside S_OUT");
    a_round_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_round != 6'd63) |=> r_state == S_ROUND)
        else $error("round sequence broken");

endmodule

`default_nettype wire

// File: design/sha256_byte_stream_hasher.sv
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream and returns the eight digest words on finish.
//
//   Channel  Signals                      Payload
//   in       i_in_valid / o_in_ready      t_in_item  (cmd, data_byte)
//   out      o_out_valid / i_out_ready    t_out_item (digest_word, word_index,
//                                                     last_word)
//
// A plain byte is taken in the idle state; the 64th byte of a block starts the
// compression, one round a cycle through the single round unit.
// Finishing pads one byte a cycle, compresses once or twice, then shows the
// eight words, each held until taken. Reset is synchronous and active low.
// ---------------------------------------------------------------------------
module sha256_byte_stream_hasher (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire sha_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output sha_pkg::t_out_item       o_out_data
);

    sha_pkg::t_dp_cmd    dp_cmd;
    sha_pkg::t_dp_status dp_status;
    logic [31:0]         hash [8];

    sha_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .o_dp_cmd(dp_cmd), .i_dp_status(dp_status), .i_hash(hash)
    );

    sha_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(dp_cmd), .o_status(dp_status), .o_hash(hash)
    );

endmodule

`default_nettype wire

// File: tb/sv/sha256_byte_stream_hasher_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Drives byte and finish requests through the input channel, predicts the
// eight digest words of every finished message and checks each returned word
// in order, under random idling on both channels.
// ---------------------------------------------------------------------------
module sha256_byte_stream_hasher_tb;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    sha_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    sha_pkg::t_out_item o_out_data;

    sha256_byte_stream_hasher dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    sha_pkg::t_in_item  pending_requests[$];
    sha_pkg::t_out_item expected_words[$];
    logic [31:0] model_hash[8];
    logic [7:0]  model_block[64];
    logic [5:0]  model_fill;
    logic [60:0] model_bytes;
    int          error_count;
    int          idle_cycles;
    bit          no_idle;
    bit          hold_off_req;
    bit          drain_req;
    int          hold_off_left;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++) begin
            w[i] = {model_block[4*i], model_block[4*i+1], model_block[4*i+2],
                    model_block[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        a = model_hash[0]; b = model_hash[1]; c = model_hash[2]; d = model_hash[3];
        e = model_hash[4]; f = model_hash[5]; g = model_hash[6]; h = model_hash[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + sha_pkg::ROUND_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        model_hash[0] += a; model_hash[1] += b; model_hash[2] += c; model_hash[3] += d;
        model_hash[4] += e; model_hash[5] += f; model_hash[6] += g; model_hash[7] += h;
    endtask

    task automatic clear_message();
        for (int i = 0; i < 8; i++) model_hash[i] = sha_pkg::INIT_H[i];
        model_fill  = '0;
        model_bytes = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] value);
        model_block[model_fill] = value;
        model_fill  = model_fill + 6'd1;
        model_bytes = model_bytes + 61'd1;
        if (model_fill == 6'd0) compress_block();
    endtask

    task automatic finish_message();
        logic [63:0]        bits;
        int                 pos;
        sha_pkg::t_out_item word;
        bits = {model_bytes, 3'b000};
        pos = int'(model_fill);
        model_block[pos] = sha_pkg::PAD_BYTE;
        pos++;
        if (pos > int'(sha_pkg::LEN_OFFSET)) begin
            for (int i = pos; i < 64; i++) model_block[i] = 8'h00;
            compress_block();
            pos = 0;
        end
        for (int i = pos; i < int'(sha_pkg::LEN_OFFSET); i++) model_block[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            model_block[int'(sha_pkg::LEN_OFFSET) + i] = bits[63 - 8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            word.digest_word = model_hash[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == 7);
            expected_words   = {expected_words, word};
        end
        clear_message();
    endtask

    task automatic predict_digest(input sha_pkg::t_in_item req);
        case (sha_pkg::t_cmd'(req.cmd))
            sha_pkg::CMD_ABSORB: begin
                absorb_byte(req.data_byte);
            end
            sha_pkg::CMD_ABSORB_FINISH: begin
                absorb_byte(req.data_byte);
                finish_message();
            end
            sha_pkg::CMD_FINISH: begin
                finish_message();
            end
            default: begin
            end
        endcase
    endtask

    function automatic sha_pkg::t_in_item make_request(input sha_pkg::t_cmd cmd,
                                                       input logic [7:0] value);
        sha_pkg::t_in_item req;
        req.cmd       = cmd;
        req.data_byte = value;
        return req;
    endfunction

    task automatic queue_request(input sha_pkg::t_cmd cmd, input logic [7:0] value);
        pending_requests = {pending_requests, make_request(cmd, value)};
    endtask

    task automatic add_message(input int length, input bit random_bytes);
        for (int i = 0; i < length - 1; i++) begin
            queue_request(sha_pkg::CMD_ABSORB, random_bytes ? 8'($urandom) : 8'(i));
            if ($urandom_range(0, 19) == 0)
                queue_request(sha_pkg::CMD_NONE, 8'($urandom));
        end
        if (length == 0 || $urandom_range(0, 1) == 0) begin
            if (length > 0) queue_request(sha_pkg::CMD_ABSORB, 8'($urandom));
            queue_request(sha_pkg::CMD_FINISH, 8'($urandom));
        end else begin
            queue_request(sha_pkg::CMD_ABSORB_FINISH, 8'($urandom));
        end
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else if (!i_in_valid || o_in_ready) begin
            if (!drain_req && pending_requests.size() > 0 &&
                (no_idle || $urandom_range(0, 99) >= 33)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_requests.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Prediction and monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_message();
            idle_cycles <= 0;
        end else begin
            if (i_in_valid && o_in_ready) predict_digest(i_in_data);
            if (o_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected digest word %h", o_out_data.digest_word);
                    error_count++;
                end else begin
                    sha_pkg::t_out_item exp_word;
                    exp_word = expected_words.pop_front();
                    if (o_out_data.digest_word !== exp_word.digest_word) begin
                        $error("digest_word expected %h actual %h",
                               exp_word.digest_word, o_out_data.digest_word);
                        error_count++;
                    end
                    if (o_out_data.word_index !== exp_word.word_index) begin
                        $error("word_index expected %0d actual %0d",
                               exp_word.word_index, o_out_data.word_index);
                        error_count++;
                    end
                    if (o_out_data.last_word !== exp_word.last_word) begin
                        $error("last_word expected %0d actual %0d",
                               exp_word.last_word, o_out_data.last_word);
                        error_count++;
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver ready, with a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready   <= 1'b0;
            hold_off_left <= 0;
        end else if (hold_off_req && hold_off_left == 0) begin
            hold_off_left <= 600;
            i_out_ready   <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            i_out_ready   <= (hold_off_left == 1);
        end else begin
            i_out_ready <= no_idle || ($urandom_range(0, 99) >= 33);
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        no_idle       = 1'b0;
        hold_off_req  = 1'b0;
        drain_req     = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty message, ignored command, extreme byte values, short messages.
        queue_request(sha_pkg::CMD_FINISH, 8'hff);
        queue_request(sha_pkg::CMD_NONE, 8'hff);
        queue_request(sha_pkg::CMD_ABSORB_FINISH, 8'h00);
        queue_request(sha_pkg::CMD_ABSORB, 8'hff);
        queue_request(sha_pkg::CMD_ABSORB_FINISH, 8'h80);
        queue_request(sha_pkg::CMD_ABSORB, 8'h55);
        queue_request(sha_pkg::CMD_ABSORB, 8'haa);
        queue_request(sha_pkg::CMD_FINISH, 8'h00);
        wait (pending_requests.size() == 0);

        // A long stretch with no idling on either side.
        no_idle = 1'b1;
        add_message(55, 1'b0);
        wait (pending_requests.size() == 0);
        wait (!i_in_valid);
        wait (expected_words.size() == 0);
        no_idle = 1'b0;

        add_message(56, 1'b1);
        add_message(64, 1'b1);

        // The receiver holds off while the sender keeps offering.
        wait (pending_requests.size() < 100);
        hold_off_req = 1'b1;
        wait (hold_off_left > 0);
        hold_off_req = 1'b0;
        wait (pending_requests.size() == 0);

        // The sender pauses until every digest word has come back.
        drain_req = 1'b1;
        wait (!i_in_valid);
        wait (expected_words.size() == 0);
        drain_req = 1'b0;

        wait (pending_requests.size() == 0 && !i_in_valid);
        wait (expected_words.size() == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
